[design/nit_pkg.sv]
// Shared types, constants and register codes for the typematic navigation block.
`default_nettype none
package nit_pkg;

	// Width of the time base and of the repeat deadlines
	localparam int TIME_BITS = 32;

	// Field widths
	localparam int NOW_W   = 32;
	localparam int STICK_W = 11;
	localparam int PAD_W   = 8;
	localparam int THR_W   = 10;
	localparam int MS_W    = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_STICK_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_RATE     = 2'd2;

	// Register reset values
	localparam logic [THR_W-1:0] THRESHOLD_RST = 10'd256;
	localparam logic [MS_W-1:0]  DELAY_RST     = 16'd350;
	localparam logic [MS_W-1:0]  RATE_RST      = 16'd110;

	typedef logic [TIME_BITS-1:0] time_t;

	// One bit per direction; bit 0 is up
	typedef struct packed {
		logic right;
		logic left;
		logic down;
		logic up;
	} dir_t;

	typedef enum logic [2:0] {
		ACT_NONE  = 3'd0,
		ACT_UP    = 3'd1,
		ACT_DOWN  = 3'd2,
		ACT_ENTER = 3'd3,
		ACT_BACK  = 3'd4,
		ACT_LEFT  = 3'd5,
		ACT_RIGHT = 3'd6
	} action_t;

endpackage
`default_nettype wire

[design/nav_input_typematic_repeat.sv]
// Top level: input register, poll logic with repeat timers, action register.
//
//  channel | signals                                         | transfer when
//  --------+-------------------------------------------------+--------------------------
//  input   | now_ms stick_x stick_y pad_held pad_pressed ... | in_valid & in_ready
//  result  | action                                          | out_valid & out_ready
//  config  | cfg_index cfg_wdata                             | cfg_wr_en
//
// One poll per cycle unless stalled; stages: input register, action register.
// The poll logic and both axis deadlines update in the cycle the registered poll moves on.
// A stalled action register holds the poll in the input register; in_ready drops only
// when both stages are full.
// Reset clears the stick history, both deadlines and the registers to their defaults.
`default_nettype none
module nav_input_typematic_repeat (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire         [nit_pkg::NOW_W-1:0]      now_ms,
	input  wire  signed [nit_pkg::STICK_W-1:0]    stick_x,
	input  wire  signed [nit_pkg::STICK_W-1:0]    stick_y,
	input  wire         [nit_pkg::PAD_W-1:0]      pad_held,
	input  wire         [nit_pkg::PAD_W-1:0]      pad_pressed,
	input  wire                                  enter_pressed,
	input  wire                                  back_pressed,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic        [2:0]                    action,
	input  wire                                  cfg_wr_en,
	input  wire         [nit_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire         [nit_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	// Configuration registers
	logic [nit_pkg::THR_W-1:0] threshold_q;
	logic [nit_pkg::MS_W-1:0]  delay_q, rate_q;

	// Input stage
	logic                              valid_s1;
	logic        [nit_pkg::NOW_W-1:0]   now_s1;
	logic signed [nit_pkg::STICK_W-1:0] stick_x_s1, stick_y_s1;
	logic        [nit_pkg::PAD_W-1:0]   held_s1, pressed_s1;
	logic                              enter_s1, back_s1;

	// Result stage
	logic             out_valid_q;
	nit_pkg::action_t action_q, action_d;

	logic            advance;
	nit_pkg::time_t  now_t;
	nit_pkg::dir_t   over, rise, held, press;
	logic [1:0]      vert_fire, horz_fire;

	assign advance   = !out_valid_q || out_ready;
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign action    = action_q;
	assign now_t     = nit_pkg::TIME_BITS'(now_ms_ext(now_s1));

	function automatic logic [nit_pkg::NOW_W-1:0] now_ms_ext(
		input logic [nit_pkg::NOW_W-1:0] v);
		now_ms_ext = v;
	endfunction

	// Configuration write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= nit_pkg::THRESHOLD_RST;
			delay_q     <= nit_pkg::DELAY_RST;
			rate_q      <= nit_pkg::RATE_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				nit_pkg::REG_STICK_THRESHOLD: threshold_q <= cfg_wdata[nit_pkg::THR_W-1:0];
				nit_pkg::REG_REPEAT_DELAY:    delay_q     <= cfg_wdata;
				nit_pkg::REG_REPEAT_RATE:     rate_q      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			now_s1     <= now_ms;
			stick_x_s1 <= stick_x;
			stick_y_s1 <= stick_y;
			held_s1    <= pad_held;
			pressed_s1 <= pad_pressed;
			enter_s1   <= enter_pressed;
			back_s1    <= back_pressed;
		end
	end

	nit_stick u_stick (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (valid_s1 && advance),
		.stick_x   (stick_x_s1),
		.stick_y   (stick_y_s1),
		.threshold (threshold_q),
		.over      (over),
		.rise      (rise)
	);

	// Merge both pads with the stick
	always_comb begin
		held  = nit_pkg::dir_t'(held_s1[3:0] | held_s1[7:4]) | over;
		press = nit_pkg::dir_t'(pressed_s1[3:0] | pressed_s1[7:4]) | rise;
	end

	nit_axis u_vert (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (valid_s1 && advance),
		.press  ({press.down, press.up}),
		.held   ({held.down, held.up}),
		.now    (now_t),
		.delay  (delay_q),
		.rate   (rate_q),
		.fire   (vert_fire)
	);

	nit_axis u_horz (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (valid_s1 && advance),
		.press  ({press.right, press.left}),
		.held   ({held.right, held.left}),
		.now    (now_t),
		.delay  (delay_q),
		.rate   (rate_q),
		.fire   (horz_fire)
	);

	// Priority pick: up, down, enter, back, left, right
	always_comb begin
		if (vert_fire[0]) begin
			action_d = nit_pkg::ACT_UP;
		end else if (vert_fire[1]) begin
			action_d = nit_pkg::ACT_DOWN;
		end else if (enter_s1) begin
			action_d = nit_pkg::ACT_ENTER;
		end else if (back_s1) begin
			action_d = nit_pkg::ACT_BACK;
		end else if (horz_fire[0]) begin
			action_d = nit_pkg::ACT_LEFT;
		end else if (horz_fire[1]) begin
			action_d = nit_pkg::ACT_RIGHT;
		end else begin
			action_d = nit_pkg::ACT_NONE;
		end
	end

	// Action register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			action_q <= action_d;
		end
	end

endmodule
`default_nettype wire

[design/nit_stick.sv]
// Stick threshold compare and press edge detect against the previous poll.
`default_nettype none
module nit_stick (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              en,
	input  wire signed [nit_pkg::STICK_W-1:0] stick_x,
	input  wire signed [nit_pkg::STICK_W-1:0] stick_y,
	input  wire        [nit_pkg::THR_W-1:0]   threshold,
	output nit_pkg::dir_t                    over,
	output nit_pkg::dir_t                    rise
);

	localparam int CMP_W = nit_pkg::STICK_W + 1;

	logic signed [CMP_W-1:0] sx, sy, thr_pos, thr_neg;
	nit_pkg::dir_t           prev_over_q;

	// Compare in a width that holds both the stick and the negated threshold
	always_comb begin
		sx      = CMP_W'(stick_x);
		sy      = CMP_W'(stick_y);
		thr_pos = signed'(CMP_W'(threshold));
		thr_neg = -thr_pos;
		over.up    = sy > thr_pos;
		over.down  = sy < thr_neg;
		over.left  = sx < thr_neg;
		over.right = sx > thr_pos;
		rise = over & ~prev_over_q;
	end

	// Previous poll's over-threshold bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_over_q <= '0;
		end else if (en) begin
			prev_over_q <= over;
		end
	end

endmodule
`default_nettype wire

[design/nit_axis.sv]
// Repeat deadline for one axis: arms on a press, fires again while held.
`default_nettype none
module nit_axis (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        en,
	input  wire  [1:0]                 press,
	input  wire  [1:0]                 held,
	input  wire  nit_pkg::time_t       now,
	input  wire  [nit_pkg::MS_W-1:0]   delay,
	input  wire  [nit_pkg::MS_W-1:0]   rate,
	output logic [1:0]                 fire
);

	nit_pkg::time_t deadline_q, diff;
	logic           reached, rearm;

	// Signed wrap compare: reached when now - deadline has its top bit clear
	always_comb begin
		diff    = now - deadline_q;
		reached = !diff[nit_pkg::TIME_BITS-1];
		rearm   = (|held) && reached;
		if (|press) begin
			fire = press;
		end else if (rearm) begin
			fire = held;
		end else begin
			fire = 2'b00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadline_q <= '0;
		end else if (en) begin
			if (|press) begin
				deadline_q <= now + nit_pkg::TIME_BITS'(delay);
			end else if (rearm) begin
				deadline_q <= now + nit_pkg::TIME_BITS'(rate);
			end
		end
	end

endmodule
`default_nettype wire

[tb/tb_nav_input_typematic_repeat.sv]
// Typematic navigation testbench: each action is checked against a predicted or directed one.
module tb_nav_input_typematic_repeat;
	import nit_pkg::*;

	// Index past the register list; writes there are dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int ITEMS_PER_PHASE = 280;
	localparam int NUM_PHASES      = 8;
	localparam int LONG_HOLD       = 300;

	typedef struct {
		logic [NOW_W-1:0]          now;
		logic signed [STICK_W-1:0] sx;
		logic signed [STICK_W-1:0] sy;
		logic [PAD_W-1:0]          held;
		logic [PAD_W-1:0]          pressed;
		logic                      ent;
		logic                      bk;
	} poll_t;

	typedef struct {
		poll_t   p;
		bit      has_exp;
		action_t exp;
	} poll_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [NOW_W-1:0] now_ms = '0;
	logic signed [STICK_W-1:0] stick_x = '0;
	logic signed [STICK_W-1:0] stick_y = '0;
	logic [PAD_W-1:0] pad_held = '0;
	logic [PAD_W-1:0] pad_pressed = '0;
	logic enter_pressed = 1'b0;
	logic back_pressed = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] action;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// Typed expectation travelling with the current directed row
	bit row_has_exp = 1'b0;
	action_t row_exp = ACT_NONE;

	// Predictor copy of the registers and of the block state
	logic [THR_W-1:0] thr_cfg = THRESHOLD_RST;
	logic [MS_W-1:0] delay_cfg = DELAY_RST;
	logic [MS_W-1:0] rate_cfg = RATE_RST;
	dir_t stick_hist = '0;
	time_t vert_dl = '0;
	time_t horiz_dl = '0;

	action_t expected_actions[$];
	int mismatches = 0;

	// Idling controls
	int snd_idle_pct = 0;
	int rcv_stall_pct = 0;
	int hold_req = 0;
	int hold_left = 0;

	// Random poll generator state
	time_t gen_now = '0;
	int gen_run = 0;
	logic [PAD_W-1:0] gen_held = '0;
	logic signed [STICK_W-1:0] gen_sx = '0;
	logic signed [STICK_W-1:0] gen_sy = '0;

	nav_input_typematic_repeat dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.now_ms       (now_ms),
		.stick_x      (stick_x),
		.stick_y      (stick_y),
		.pad_held     (pad_held),
		.pad_pressed  (pad_pressed),
		.enter_pressed(enter_pressed),
		.back_pressed (back_pressed),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.action       (action),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#3000000;
		$display("TEST FAILED");
		$finish;
	end

	// Deadline reached when now - deadline has its top bit clear (wrap safe)
	function automatic bit deadline_hit(input time_t now, input time_t dl);
		time_t diff;
		diff = now - dl;
		return !diff[TIME_BITS-1];
	endfunction

	// One poll: stick to directions, merge pads, run both repeat timers, pick by priority
	function automatic action_t predict_poll(input logic [NOW_W-1:0] now,
			input logic signed [STICK_W-1:0] sx_in, input logic signed [STICK_W-1:0] sy_in,
			input logic [PAD_W-1:0] held_b, input logic [PAD_W-1:0] press_b,
			input logic ent, input logic bk);
		int sx;
		int sy;
		int t;
		dir_t over;
		dir_t rise;
		dir_t held;
		dir_t press;
		sx = sx_in;
		sy = sy_in;
		t = int'(thr_cfg);
		over = '0;
		over.up = (sy > t);
		over.down = (sy < -t);
		over.left = (sx < -t);
		over.right = (sx > t);
		rise = over & ~stick_hist;
		stick_hist = over;
		held = held_b[3:0] | held_b[7:4] | over;
		press = press_b[3:0] | press_b[7:4] | rise;

		if (press.up || press.down) begin
			vert_dl = now + delay_cfg;
		end else if ((held.up || held.down) && deadline_hit(now, vert_dl)) begin
			press.up = held.up;
			press.down = held.down;
			vert_dl = now + rate_cfg;
		end

		if (press.left || press.right) begin
			horiz_dl = now + delay_cfg;
		end else if ((held.left || held.right) && deadline_hit(now, horiz_dl)) begin
			press.left = held.left;
			press.right = held.right;
			horiz_dl = now + rate_cfg;
		end

		if (press.up) return ACT_UP;
		else if (press.down) return ACT_DOWN;
		else if (ent) return ACT_ENTER;
		else if (bk) return ACT_BACK;
		else if (press.left) return ACT_LEFT;
		else if (press.right) return ACT_RIGHT;
		return ACT_NONE;
	endfunction

	task automatic note_mismatch(input string msg);
		if (mismatches < 10)
			$display("mismatch: %s", msg);
		mismatches++;
	endtask

	// Input transfers feed the predictor; result transfers are checked in order
	always @(posedge clk) begin
		action_t predicted;
		action_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predicted = predict_poll(now_ms, stick_x, stick_y, pad_held, pad_pressed,
					enter_pressed, back_pressed);
				expected_actions.push_back(row_has_exp ? row_exp : predicted);
			end
			if (out_valid && out_ready) begin
				if (expected_actions.size() == 0) begin
					note_mismatch($sformatf("action %0d with nothing pending", action));
				end else begin
					want = expected_actions.pop_front();
					if (action !== want)
						note_mismatch($sformatf("expected action %0d, got %0d", want, action));
				end
			end
		end
	end

	// Result side: random stalls plus an occasional long hold-off
	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			REG_STICK_THRESHOLD: thr_cfg = data[THR_W-1:0];
			REG_REPEAT_DELAY:    delay_cfg = data;
			REG_REPEAT_RATE:     rate_cfg = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Offer one poll, with optional gaps before it, and wait for its transfer
	task automatic send_poll(input poll_t p, input bit has_exp, input action_t exp);
		@(negedge clk);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		now_ms <= p.now;
		stick_x <= p.sx;
		stick_y <= p.sy;
		pad_held <= p.held;
		pad_pressed <= p.pressed;
		enter_pressed <= p.ent;
		back_pressed <= p.bk;
		row_has_exp <= has_exp;
		row_exp <= exp;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Stop offering and wait, bounded, until every pending action has come back
	task automatic drain_results();
		int waited;
		waited = 0;
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_actions.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		if (expected_actions.size() != 0) begin
			note_mismatch($sformatf("%0d expected actions never arrived",
				expected_actions.size()));
			mismatches += expected_actions.size() - 1;
			expected_actions.delete();
		end
		repeat (4) @(posedge clk);
	endtask

	// Stick value: centered, at the threshold give or take 2, at plus or minus 512, or anything
	function automatic logic signed [STICK_W-1:0] pick_stick();
		int v;
		case ($urandom_range(0, 9))
			0, 1, 2: v = int'($urandom_range(0, 200)) - 100;
			3, 4, 5, 6: begin
				v = int'(thr_cfg) + int'($urandom_range(0, 4)) - 2;
				if ($urandom_range(0, 1) != 0)
					v = -v;
			end
			7: v = ($urandom_range(0, 1) != 0) ? 512 : -512;
			default: v = int'($urandom_range(0, 2047)) - 1024;
		endcase
		return v[STICK_W-1:0];
	endfunction

	function automatic logic [PAD_W-1:0] one_dir();
		return 8'(4'b0001 << $urandom_range(0, 3)) << (4 * $urandom_range(0, 1));
	endfunction

	// Random poll: mostly runs of one held pattern with a fresh press at the start
	task automatic gen_poll(output poll_t p);
		int r;
		logic [NOW_W-1:0] step;
		r = $urandom_range(0, 99);
		if (r < 70)
			step = $urandom_range(0, 40);
		else if (r < 80)
			step = (($urandom_range(0, 1) != 0) ? rate_cfg : delay_cfg) + $urandom_range(0, 2) - 1;
		else if (r < 95)
			step = $urandom_range(0, 70000);
		else
			step = $urandom;
		gen_now = gen_now + step;
		p.pressed = '0;

		if (gen_run == 0) begin
			gen_run = $urandom_range(1, 60);
			case ($urandom_range(0, 5))
				0: gen_held = '0;
				1, 2, 3: gen_held = one_dir();
				4: gen_held = one_dir() | one_dir();
				default: gen_held = 8'($urandom_range(0, 255));
			endcase
			if ($urandom_range(0, 2) == 0) begin
				gen_sx = pick_stick();
				gen_sy = pick_stick();
			end else begin
				gen_sx = STICK_W'(int'($urandom_range(0, 20)) - 10);
				gen_sy = STICK_W'(int'($urandom_range(0, 20)) - 10);
			end
			if ($urandom_range(0, 3) != 0)
				p.pressed = gen_held;
		end
		gen_run--;

		// Noise on top of the run
		if ($urandom_range(0, 7) == 0)
			gen_sx = pick_stick();
		if ($urandom_range(0, 7) == 0)
			gen_sy = pick_stick();
		if ($urandom_range(0, 24) == 0)
			p.pressed = p.pressed | 8'($urandom_range(0, 255));
		p.held = gen_held;
		if ($urandom_range(0, 24) == 0)
			p.held = p.held ^ 8'($urandom_range(0, 255));
		p.now = gen_now;
		p.sx = gen_sx;
		p.sy = gen_sy;
		p.ent = ($urandom_range(0, 11) == 0);
		p.bk = ($urandom_range(0, 11) == 0);
	endtask

	initial begin
		poll_row_t directed_rows[25];
		poll_t pp;
		int ph;
		int n;

		// Directed polls at reset settings, starting from the cleared state
		directed_rows = '{
			'{'{32'd0, 0, 0, 8'h00, 8'h00, 1'b0, 1'b0}, 1'b1, ACT_NONE},
			'{'{32'd10, 0, 0, 8'h00, 8'h00, 1'b1, 1'b1}, 1'b1, ACT_ENTER},
			'{'{32'd20, 0, 0, 8'h00, 8'h00, 1'b0, 1'b1}, 1'b1, ACT_BACK},
			'{'{32'd30, 0, 0, 8'h01, 8'h01, 1'b0, 1'b0}, 1'b1, ACT_UP},
			'{'{32'd40, 0, 0, 8'h01, 8'h00, 1'b0, 1'b0}, 1'b1, ACT_NONE},
			'{'{32'd380, 0, 0, 8'h01, 8'h00, 1'b0, 1'b0}, 1'b0, ACT_NONE},
			'{'{32'd400, 0, 0, 8'h10, 8'h20, 1'b0, 1'b0}, 1'b1, ACT_DOWN},
			'{'{32'd500, 0, 0, 8'h04, 8'h04, 1'b0, 1'b0}, 1'b1, ACT_LEFT},
			'{'{32'd510, 0, 0, 8'h00, 8'h80, 1'b0, 1'b0}, 1'b1, ACT_RIGHT},
			'{'{32'd520, 0, 0, 8'h0C, 8'h0C, 1'b0, 1'b0}, 1'b1, ACT_LEFT},
			'{'{32'd530, 512, 0, 8'h00, 8'h00, 1'b0, 1'b0}, 1'b1, ACT_RIGHT},
			'{'{32'd540, 512, 0, 8'h00, 8'h00, 1'b0, 1'b0}, 1'b0, ACT_NONE},
			'{'{32'd550, -512, 512, 8'h00, 8'h00, 1'b0, 1'b0}, 1'b1, ACT_UP},
			// exactly at the threshold does not count
			'{'{32'd560, 256, -256, 8'h00, 8'h00, 1'b0, 1'b0}, 1'b1, ACT_NONE},
			'{'{32'd570, 0, -257, 8'h00, 8'h00, 1'b0, 1'b0}, 1'b1, ACT_DOWN},
			'{'{32'd580, 257, 257, 8'h00, 8'h00, 1'b0, 1'b0}, 1'b0, ACT_NONE},
			// both directions of an axis held during a repeat
			'{'{32'd2000, 0, 0, 8'h03, 8'h00, 1'b0, 1'b0}, 1'b0, ACT_NONE},
			'{'{32'd2001, 0, 0, 8'hC0, 8'h00, 1'b0, 1'b0}, 1'b0, ACT_NONE},
			// deadline armed across the time wrap
			'{'{32'hFFFF_FFF0, 0, 0, 8'h01, 8'h01, 1'b0, 1'b0}, 1'b1, ACT_UP},
			'{'{32'h0000_0100, 0, 0, 8'h01, 8'h00, 1'b0, 1'b0}, 1'b1, ACT_NONE},
			'{'{32'd334, 0, 0, 8'h01, 8'h00, 1'b0, 1'b0}, 1'b0, ACT_NONE},
			'{'{32'd340, 0, 0, 8'h04, 8'h04, 1'b1, 1'b0}, 1'b1, ACT_ENTER},
			// half the time space away reads as not reached
			'{'{32'h8000_01BC, 0, 0, 8'h01, 8'h00, 1'b0, 1'b0}, 1'b0, ACT_NONE},
			'{'{32'hFFFF_FFFF, -1024, 1023, 8'hFF, 8'hFF, 1'b1, 1'b1}, 1'b0, ACT_NONE},
			'{'{32'd0, 0, 0, 8'h00, 8'h00, 1'b0, 1'b0}, 1'b0, ACT_NONE}
		};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_poll(directed_rows[i].p, directed_rows[i].has_exp, directed_rows[i].exp);

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph > 0) begin
				drain_results();
				// Register settings per phase, extremes first
				case (ph)
					1: begin
						write_reg(REG_STICK_THRESHOLD, 16'd0);
						write_reg(REG_REPEAT_DELAY, 16'd0);
						write_reg(REG_REPEAT_RATE, 16'd0);
					end
					2: begin
						write_reg(REG_STICK_THRESHOLD, 16'd512);
						write_reg(REG_REPEAT_DELAY, 16'hFFFF);
						write_reg(REG_REPEAT_RATE, 16'hFFFF);
					end
					3: begin
						write_reg(REG_STICK_THRESHOLD, 16'hFFFF);
						write_reg(REG_REPEAT_DELAY, 16'd0);
						write_reg(REG_REPEAT_RATE, 16'd1);
						write_reg(REG_UNUSED, 16'($urandom));
					end
					4, 5: begin
						write_reg(REG_STICK_THRESHOLD, 16'($urandom_range(0, 512)));
						write_reg(REG_REPEAT_DELAY, 16'($urandom_range(0, 1000)));
						write_reg(REG_REPEAT_RATE, 16'($urandom_range(1, 300)));
					end
					6: begin
						write_reg(REG_STICK_THRESHOLD, 16'($urandom));
						write_reg(REG_REPEAT_DELAY, 16'($urandom));
						write_reg(REG_REPEAT_RATE, 16'($urandom_range(1, 65535)));
						write_reg(REG_UNUSED, 16'($urandom));
					end
					default: begin
						write_reg(REG_STICK_THRESHOLD, 16'(THRESHOLD_RST));
						write_reg(REG_REPEAT_DELAY, DELAY_RST);
						write_reg(REG_REPEAT_RATE, RATE_RST);
					end
				endcase
				gen_now = (ph == NUM_PHASES - 1) ? 32'hFFFF_F000 : $urandom;
				gen_run = 0;
			end

			// Idling mode cycles through none, sender, receiver, both
			case (ph % 4)
				0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
				1: begin snd_idle_pct = 50; rcv_stall_pct = 0;  end
				2: begin snd_idle_pct = 0;  rcv_stall_pct = 50; end
				default: begin snd_idle_pct = 20; rcv_stall_pct = 20; end
			endcase

			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ((ph == 2 || ph == 6) && n == 100)
					hold_req = LONG_HOLD;
				if (ph == 4 && n % 70 == 69)
					drain_results();
				gen_poll(pp);
				send_poll(pp, 1'b0, ACT_NONE);
			end
		end

		drain_results();
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
